@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/spq_pkg.sv @@
// Package: types, codes and defaults for the sorted priority queue
package spq_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int CODE_W = 16;
	localparam int PRIO_W = 8;
	localparam int OCC_W  = 5;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STS_INSERTED = 2'd0,
		STS_REMOVED  = 2'd1,
		STS_EMPTY    = 2'd2,
		STS_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_HOLD = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		op_t     op;
		status_t status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
	} dp_stat_t;

endpackage

@@ hw/rtl/spq_ctrl.sv @@
// Controller: handshake state machine and operation decode
module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     action,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t dp_stat,
	output cmd_t     cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				// stay loaded when a new transaction replaces the one taken
				if (m_tready && !accept) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE) || m_tready;
		m_tvalid   = (state_q == ST_HOLD);
		cmd.load   = accept;
		cmd.op     = OP_NONE;
		cmd.status = STS_INSERTED;
		if (action == ACT_INSERT) begin
			if (dp_stat.full) begin
				cmd.status = STS_FULL;
			end else begin
				cmd.op     = accept ? OP_INSERT : OP_NONE;
				cmd.status = STS_INSERTED;
			end
		end else begin
			if (dp_stat.empty) begin
				cmd.status = STS_EMPTY;
			end else begin
				cmd.op     = accept ? OP_REMOVE : OP_NONE;
				cmd.status = STS_REMOVED;
			end
		end
	end

endmodule

@@ hw/rtl/spq_dp.sv @@
// Datapath: sorted entry cells with per-cell compare and shift, result register
module spq_dp import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [CODE_W-1:0] in_code,
	input  logic [PRIO_W-1:0] in_prio,
	output dp_stat_t          dp_stat,
	output logic [CODE_W-1:0] res_code,
	output logic [PRIO_W-1:0] res_prio,
	output status_t           res_status,
	output logic [OCC_W-1:0]  res_occ
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CODE_W-1:0] code_q [CAPACITY];
	logic [PRIO_W-1:0] prio_q [CAPACITY];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [CAPACITY-1:0] le;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [CODE_W-1:0] ins_code;
			logic [PRIO_W-1:0] ins_prio;
			logic [CODE_W-1:0] rm_code;
			logic [PRIO_W-1:0] rm_prio;

			// valid entry that the new one goes behind
			assign le[gi] = (CNT_W'(gi) < count_q) && (prio_q[gi] <= in_prio);

			if (gi == 0) begin : g_first
				assign ins_code = in_code;
				assign ins_prio = in_prio;
			end else begin : g_rest
				assign ins_code = le[gi-1] ? in_code : code_q[gi-1];
				assign ins_prio = le[gi-1] ? in_prio : prio_q[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign rm_code = code_q[gi];
				assign rm_prio = prio_q[gi];
			end else begin : g_inner
				assign rm_code = code_q[gi+1];
				assign rm_prio = prio_q[gi+1];
			end

			always_ff @(posedge clk) begin
				case (cmd.op)
					OP_INSERT: begin
						if (!le[gi]) begin
							code_q[gi] <= ins_code;
							prio_q[gi] <= ins_prio;
						end
					end
					OP_REMOVE: begin
						code_q[gi] <= rm_code;
						prio_q[gi] <= rm_prio;
					end
					default: begin
					end
				endcase
			end
		end
	endgenerate

	always_comb begin
		case (cmd.op)
			OP_INSERT: count_d = count_q + CNT_W'(1);
			OP_REMOVE: count_d = count_q - CNT_W'(1);
			default:   count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign dp_stat.empty = (count_q == '0);
	assign dp_stat.full  = (count_q == CNT_W'(CAPACITY));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status <= cmd.status;
			res_occ    <= OCC_W'(count_d);
			if (cmd.op == OP_REMOVE) begin
				res_code <= code_q[0];
				res_prio <= prio_q[0];
			end else begin
				res_code <= '0;
				res_prio <= '0;
			end
		end
	end

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// Top level: sorted priority queue with insert and remove-min
//
// Channel   Dir  Contents
// s_*       in   tdata: code[15:0], priority_req[23:16]; tuser: action
// m_*       out  tdata: out_code[15:0], out_priority[23:16], occupancy[28:24]; tuser: status
//
// One transaction per cycle while the output is not stalled: every cell compares
// its priority with the request and shifts or loads in the same cycle.
// A new transaction is taken while the previous result is being taken.
// Reset empties the queue; entry contents are not cleared.
// A stalled output holds its result and blocks further input.
`include "assert_macros.svh"

module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // code[15:0], priority_req[23:16]
	input  logic        s_tuser,  // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_code[15:0], out_priority[23:16], occupancy[28:24]
	output logic [1:0]  m_tuser   // status[1:0]
);

	cmd_t              cmd;
	dp_stat_t          dp_stat;
	logic [CODE_W-1:0] res_code;
	logic [PRIO_W-1:0] res_prio;
	status_t           res_status;
	logic [OCC_W-1:0]  res_occ;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_stat  (dp_stat),
		.cmd      (cmd)
	);

	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_code    (s_tdata[15:0]),
		.in_prio    (s_tdata[23:16]),
		.dp_stat    (dp_stat),
		.res_code   (res_code),
		.res_prio   (res_prio),
		.res_status (res_status),
		.res_occ    (res_occ)
	);

	assign m_tdata = {3'b000, res_occ, res_prio, res_code};
	assign m_tuser = res_status;

	`ASSERT_NEVER(a_full_and_empty, dp_stat.full && dp_stat.empty, "queue both full and empty")
	`ASSERT_CLK(a_no_insert_full, cmd.op == OP_INSERT |-> !dp_stat.full, "insert into full queue")
	`ASSERT_CLK(a_no_remove_empty, cmd.op == OP_REMOVE |-> !dp_stat.empty, "remove from empty queue")
	`ASSERT_CLK(a_result_follows, s_tvalid && s_tready |=> m_tvalid, "accepted transaction gave no result")

endmodule
